// ===== src/pcpa_pkg.sv =====
// Shared types and constants of the polyline closest-point arc-length core.
`timescale 1ns / 1ps

package pcpa_pkg;

    // Output word width and fraction bits of the projection parameter
    localparam int OUT_W  = 32;
    localparam int T_FRAC = 32;

    // Multiply phases of one segment
    localparam logic [2:0] PH_WV = 3'd0;   // dot product terms
    localparam logic [2:0] PH_VV = 3'd1;   // squared segment length terms
    localparam logic [2:0] PH_TV = 3'd2;   // projected offsets
    localparam logic [2:0] PH_GG = 3'd3;   // squared distance terms
    localparam logic [2:0] PH_TL = 3'd4;   // arc increment

    // Classification of a queued word
    typedef struct packed {
        logic start;   // opens a polyline: latch query, clear best
        logic last;    // closes it: one result follows
    } ctl_t;

endpackage

// ===== src/pcpa_front.sv =====
// Front end: accepts waypoint words, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module pcpa_front #(
    parameter int COORD_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [6*COORD_BITS-1:0]   in_data,
    input  logic                      in_first,
    input  logic                      in_last,
    output logic                      q_valid,
    input  logic                      q_ready,
    output logic [6*COORD_BITS-1:0]   q_data,
    output pcpa_pkg::ctl_t            q_ctl
);

    localparam int DW    = 6 * COORD_BITS;
    localparam int DEPTH = 2;

    logic [DW-1:0]          data_mem [DEPTH];
    pcpa_pkg::ctl_t         ctl_mem  [DEPTH];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             count_reg, count_next;
    logic                   started_reg, started_next;
    logic                   push, pop;
    pcpa_pkg::ctl_t         in_ctl;

    assign in_ready = (count_reg != 2'(DEPTH));
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = data_mem[rd_ptr_reg];
    assign q_ctl    = ctl_mem[rd_ptr_reg];

    // classify: a word with no open polyline starts one
    always_comb begin
        in_ctl.start = in_first || !started_reg;
        in_ctl.last  = in_last;
    end

    always_comb begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        count_next   = count_reg;
        started_next = started_reg;
        if (push) begin
            wr_ptr_next  = ~wr_ptr_reg;
            started_next = !in_last;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            count_reg   <= 2'd0;
            started_reg <= 1'b0;
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
            started_reg <= started_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            data_mem[wr_ptr_reg] <= in_data;
            ctl_mem[wr_ptr_reg]  <= in_ctl;
        end
    end

endmodule

// ===== src/pcpa_back.sv =====
// Back end: per-segment projection, running minimum and arc length, result register.
`timescale 1ns / 1ps

module pcpa_back #(
    parameter int COORD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [6*COORD_BITS-1:0]       q_data,
    input  pcpa_pkg::ctl_t                q_ctl,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pcpa_pkg::OUT_W-1:0]    out_data
);

    localparam int C  = COORD_BITS;
    localparam int M  = C + 1;          // difference magnitude
    localparam int W  = 2 * C + 4;      // dot product, squared length
    localparam int R  = C + 2;          // segment length
    localparam int GW = C + 4;          // distance offset magnitude
    localparam int G  = 2 * C + 10;     // squared distance
    localparam int P  = C + 34;         // multiplier operand
    localparam int TW = pcpa_pkg::T_FRAC + 1;
    localparam int OW = pcpa_pkg::OUT_W;
    localparam int SCW = $clog2(R + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MLOAD = 4'd1;
    localparam logic [3:0] S_MRUN  = 4'd2;
    localparam logic [3:0] S_MPOST = 4'd3;
    localparam logic [3:0] S_TQ    = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    localparam logic [TW-1:0]  T_ONE  = TW'(1) << pcpa_pkg::T_FRAC;
    localparam logic [2*P-1:0] T_HALF = (2*P)'(1) << (pcpa_pkg::T_FRAC - 1);

    // saturating add onto a 32-bit arc length
    function automatic logic [OW-1:0] sat_add(input logic [OW-1:0] a,
                                              input logic [R-1:0] b);
        logic [R:0] s;
        s = R'(a) + b;
        if (s > (R+1)'({OW{1'b1}})) begin
            sat_add = {OW{1'b1}};
        end else begin
            sat_add = s[OW-1:0];
        end
    endfunction

    logic [3:0]           state_reg, state_next;
    logic [2:0]           ph_reg, ph_next;
    logic [1:0]           ax_reg, ax_next;
    logic                 last_reg, last_next;
    logic [C-1:0]         prev_reg [3];
    logic [C-1:0]         prev_next [3];
    logic [C-1:0]         wp_reg [3];
    logic [C-1:0]         wp_next [3];
    logic [C-1:0]         hq_reg [3];
    logic [C-1:0]         hq_next [3];
    logic [M-1:0]         vmag_reg [3];
    logic [M-1:0]         vmag_next [3];
    logic                 vneg_reg [3];
    logic                 vneg_next [3];
    logic signed [C:0]    w_reg [3];
    logic signed [C:0]    w_next [3];
    logic [GW-1:0]        gmag_reg [3];
    logic [GW-1:0]        gmag_next [3];
    logic [W-1:0]         pos_reg, pos_next;
    logic [W-1:0]         neg_reg, neg_next;
    logic [W-1:0]         den_reg, den_next;
    logic [G-1:0]         gap_reg, gap_next;
    logic [G-1:0]         best_gap_reg, best_gap_next;
    logic [OW-1:0]        best_along_reg, best_along_next;
    logic [OW-1:0]        run_reg, run_next;
    logic [TW-1:0]        tq_reg, tq_next;
    logic [W:0]           rem_reg, rem_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [W-1:0]         sx_reg, sx_next;
    logic [R+1:0]         srem_reg, srem_next;
    logic [R-1:0]         len_reg, len_next;
    logic [SCW-1:0]       scnt_reg, scnt_next;
    logic [2*P-1:0]       ma_reg, ma_next;
    logic [P-1:0]         mb_reg, mb_next;
    logic [2*P-1:0]       acc_reg, acc_next;
    logic                 ov_reg, ov_next;
    logic [OW-1:0]        od_reg, od_next;

    // per-word combinational helpers
    logic signed [C:0]    v_d [3];
    logic signed [C:0]    w_d [3];
    logic [2*P-1:0]       rnd;
    logic [R-1:0]         m_mag;
    logic signed [GW-1:0] s_val;
    logic signed [GW-1:0] g_val;
    logic [W:0]           r_sh;
    logic [R+1:0]         s_trial;
    logic [R+1:0]         s_rem;

    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // differences of the incoming waypoint and the held query to the previous waypoint
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v_d[i] = $signed({q_data[i*C + C-1], q_data[i*C +: C]})
                   - $signed({prev_reg[i][C-1], prev_reg[i]});
            w_d[i] = $signed({hq_reg[i][C-1], hq_reg[i]})
                   - $signed({prev_reg[i][C-1], prev_reg[i]});
        end
    end

    // rounding of the projected offset and the distance offset
    always_comb begin
        rnd   = acc_reg + T_HALF;
        m_mag = rnd[pcpa_pkg::T_FRAC +: R];
        s_val = vneg_reg[ax_reg] ? -$signed({2'b00, m_mag}) : $signed({2'b00, m_mag});
        g_val = s_val - GW'(w_reg[ax_reg]);
    end

    // one restoring divide step and one square root step
    always_comb begin
        r_sh    = {rem_reg[W-1:0], 1'b0};
        s_rem   = {srem_reg[R-1:0], sx_reg[W-1 -: 2]};
        s_trial = {len_reg, 2'b01};
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        ph_next         = ph_reg;
        ax_next         = ax_reg;
        last_next       = last_reg;
        prev_next       = prev_reg;
        wp_next         = wp_reg;
        hq_next         = hq_reg;
        vmag_next       = vmag_reg;
        vneg_next       = vneg_reg;
        w_next          = w_reg;
        gmag_next       = gmag_reg;
        pos_next        = pos_reg;
        neg_next        = neg_reg;
        den_next        = den_reg;
        gap_next        = gap_reg;
        best_gap_next   = best_gap_reg;
        best_along_next = best_along_reg;
        run_next        = run_reg;
        tq_next         = tq_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        sx_next         = sx_reg;
        srem_next       = srem_reg;
        len_next        = len_reg;
        scnt_next       = scnt_reg;
        ma_next         = ma_reg;
        mb_next         = mb_reg;
        acc_next        = acc_reg;
        ov_next         = ov_reg;
        od_next         = od_reg;

        if (ov_reg && out_ready) begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    last_next = q_ctl.last;
                    for (int i = 0; i < 3; i++) begin
                        wp_next[i]   = q_data[i*C +: C];
                        vneg_next[i] = v_d[i][C];
                        vmag_next[i] = v_d[i][C] ? M'(-v_d[i]) : M'(v_d[i]);
                        w_next[i]    = w_d[i];
                    end
                    if (q_ctl.start) begin
                        for (int i = 0; i < 3; i++) begin
                            hq_next[i] = q_data[(i+3)*C +: C];
                        end
                        best_gap_next   = {G{1'b1}};
                        best_along_next = '0;
                        run_next        = '0;
                        state_next      = S_UPD;
                    end else begin
                        pos_next   = '0;
                        neg_next   = '0;
                        den_next   = '0;
                        gap_next   = '0;
                        ph_next    = pcpa_pkg::PH_WV;
                        ax_next    = 2'd0;
                        state_next = S_MLOAD;
                    end
                end
            end
            S_MLOAD: begin
                acc_next = '0;
                case (ph_reg)
                    pcpa_pkg::PH_WV: begin
                        ma_next = (2*P)'(w_reg[ax_reg][C] ? M'(-w_reg[ax_reg])
                                                          : M'(w_reg[ax_reg]));
                        mb_next = P'(vmag_reg[ax_reg]);
                    end
                    pcpa_pkg::PH_VV: begin
                        ma_next = (2*P)'(vmag_reg[ax_reg]);
                        mb_next = P'(vmag_reg[ax_reg]);
                    end
                    pcpa_pkg::PH_TV: begin
                        ma_next = (2*P)'(vmag_reg[ax_reg]);
                        mb_next = P'(tq_reg);
                    end
                    pcpa_pkg::PH_GG: begin
                        ma_next = (2*P)'(gmag_reg[ax_reg]);
                        mb_next = P'(gmag_reg[ax_reg]);
                    end
                    default: begin
                        ma_next = (2*P)'(len_reg);
                        mb_next = P'(tq_reg);
                    end
                endcase
                state_next = S_MRUN;
            end
            S_MRUN: begin
                // shift-add, one multiplier bit a cycle, stops when the rest is zero
                if (mb_reg == '0) begin
                    state_next = S_MPOST;
                end else begin
                    if (mb_reg[0]) begin
                        acc_next = acc_reg + ma_reg;
                    end
                    ma_next = {ma_reg[2*P-2:0], 1'b0};
                    mb_next = {1'b0, mb_reg[P-1:1]};
                end
            end
            S_MPOST: begin
                ax_next    = ax_reg + 2'd1;
                state_next = S_MLOAD;
                case (ph_reg)
                    pcpa_pkg::PH_WV: begin
                        if (w_reg[ax_reg][C] != vneg_reg[ax_reg]) begin
                            neg_next = neg_reg + acc_reg[W-1:0];
                        end else begin
                            pos_next = pos_reg + acc_reg[W-1:0];
                        end
                        if (ax_reg == 2'd2) begin
                            ax_next = 2'd0;
                            ph_next = pcpa_pkg::PH_VV;
                        end
                    end
                    pcpa_pkg::PH_VV: begin
                        den_next = den_reg + acc_reg[W-1:0];
                        if (ax_reg == 2'd2) begin
                            ax_next    = 2'd0;
                            state_next = S_TQ;
                        end
                    end
                    pcpa_pkg::PH_TV: begin
                        gmag_next[ax_reg] = g_val[GW-1] ? GW'(-g_val) : GW'(g_val);
                        if (ax_reg == 2'd2) begin
                            ax_next = 2'd0;
                            ph_next = pcpa_pkg::PH_GG;
                        end
                    end
                    pcpa_pkg::PH_GG: begin
                        gap_next = gap_reg + acc_reg[G-1:0];
                        if (ax_reg == 2'd2) begin
                            ax_next    = 2'd0;
                            sx_next    = den_reg;
                            srem_next  = '0;
                            len_next   = '0;
                            scnt_next  = SCW'(R);
                            state_next = S_SQRT;
                        end
                    end
                    default: begin
                        best_gap_next   = gap_reg;
                        best_along_next = sat_add(run_reg,
                                                  acc_reg[pcpa_pkg::T_FRAC +: R]);
                        state_next      = S_UPD;
                    end
                endcase
            end
            S_TQ: begin
                // clamp of the projection parameter; zero length takes t = 1
                ph_next    = pcpa_pkg::PH_TV;
                state_next = S_MLOAD;
                if (den_reg == '0) begin
                    tq_next = T_ONE;
                end else if (neg_reg >= pos_reg) begin
                    tq_next = '0;
                end else if ((pos_reg - neg_reg) >= den_reg) begin
                    tq_next = T_ONE;
                end else begin
                    rem_next   = {1'b0, pos_reg - neg_reg};
                    tq_next    = '0;
                    cnt_next   = 6'(pcpa_pkg::T_FRAC);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (cnt_reg == 6'd0) begin
                    state_next = S_MLOAD;
                end else begin
                    cnt_next = cnt_reg - 6'd1;
                    if (r_sh >= {1'b0, den_reg}) begin
                        rem_next = r_sh - {1'b0, den_reg};
                        tq_next  = {tq_reg[TW-2:0], 1'b1};
                    end else begin
                        rem_next = r_sh;
                        tq_next  = {tq_reg[TW-2:0], 1'b0};
                    end
                end
            end
            S_SQRT: begin
                // digit-by-digit root of the squared length
                if (scnt_reg == '0) begin
                    state_next = S_CMP;
                end else begin
                    scnt_next = scnt_reg - SCW'(1);
                    sx_next   = {sx_reg[W-3:0], 2'b00};
                    if (s_rem >= s_trial) begin
                        srem_next = s_rem - s_trial;
                        len_next  = {len_reg[R-2:0], 1'b1};
                    end else begin
                        srem_next = s_rem;
                        len_next  = {len_reg[R-2:0], 1'b0};
                    end
                end
            end
            S_CMP: begin
                // strictly smaller wins, so the earliest segment keeps a tie
                if (gap_reg < best_gap_reg) begin
                    ph_next    = pcpa_pkg::PH_TL;
                    state_next = S_MLOAD;
                end else begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                if (ph_reg != pcpa_pkg::PH_WV || state_reg != S_IDLE) begin
                    run_next = (last_reg && 1'b0) ? run_reg : run_reg;
                end
                prev_next  = wp_reg;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (!ov_reg) begin
                    ov_next    = 1'b1;
                    od_next    = best_along_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // arc length grows by the segment length once the segment is done
    logic seg_reg, seg_next;
    always_comb begin
        seg_next = seg_reg;
        if (state_reg == S_IDLE && q_valid) begin
            seg_next = !q_ctl.start;
        end
    end

    logic [OW-1:0] run_upd;
    assign run_upd = (state_reg == S_UPD && seg_reg) ? sat_add(run_reg, len_reg) : run_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ph_reg         <= pcpa_pkg::PH_WV;
            ax_reg         <= 2'd0;
            last_reg       <= 1'b0;
            seg_reg        <= 1'b0;
            ov_reg         <= 1'b0;
            best_gap_reg   <= {G{1'b1}};
            best_along_reg <= '0;
            run_reg        <= '0;
            for (int i = 0; i < 3; i++) begin
                prev_reg[i] <= '0;
                hq_reg[i]   <= '0;
            end
        end else begin
            state_reg      <= state_next;
            ph_reg         <= ph_next;
            ax_reg         <= ax_next;
            last_reg       <= last_next;
            seg_reg        <= seg_next;
            ov_reg         <= ov_next;
            best_gap_reg   <= best_gap_next;
            best_along_reg <= best_along_next;
            run_reg        <= run_upd;
            prev_reg       <= prev_next;
            hq_reg         <= hq_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        wp_reg   <= wp_next;
        vmag_reg <= vmag_next;
        vneg_reg <= vneg_next;
        w_reg    <= w_next;
        gmag_reg <= gmag_next;
        pos_reg  <= pos_next;
        neg_reg  <= neg_next;
        den_reg  <= den_next;
        gap_reg  <= gap_next;
        tq_reg   <= tq_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        sx_reg   <= sx_next;
        srem_reg <= srem_next;
        len_reg  <= len_next;
        scnt_reg <= scnt_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        acc_reg  <= acc_next;
        od_reg   <= od_next;
    end

endmodule

// ===== src/polyline_closest_point_arclength_core.sv =====
// Top level of the polyline closest-point arc-length core.
`timescale 1ns / 1ps

// Streams the waypoints of a 3-D polyline and returns the arc length from the
// first waypoint to the point on the polyline closest to a query point.
// Slave channel: one word per waypoint; tdata carries the waypoint and the
// query point (query taken on the first word), tuser marks the first word,
// tlast the final one. Master channel: one word per polyline, sent after the
// word marked tlast, holding the arc length (unsigned, saturating).
// Words pass through a two-entry queue into a sequencer that handles one at a
// time. A first word latches the query and clears the running state. A segment
// word takes 12 or 13 multiplies on one shared shift-add multiplier, plus a
// restoring divide when the projection parameter is not clamped and a
// digit-by-digit root of the squared segment length. With the sequencer free,
// m_tvalid rises once the sequencer has finished the last word.
// Reset (aresetn low, synchronous) empties the queue and clears the running
// state; no polyline is open afterwards. A stalled master holds its result
// word, the sequencer waits at the next result, and the queue then fills and
// drops s_tready.
module polyline_closest_point_arclength_core #(
    parameter int COORD_BITS = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // wp_x, wp_y, wp_z, query_x, query_y, query_z, zero pad
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    // first_point
    input  logic                                    s_tuser,
    input  logic                                    s_tlast,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // along_distance
    output logic [pcpa_pkg::OUT_W-1:0]              m_tdata
);

    localparam int DW = 6 * COORD_BITS;

    logic                   q_valid;
    logic                   q_ready;
    logic [DW-1:0]          q_data;
    pcpa_pkg::ctl_t         q_ctl;

    pcpa_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata[DW-1:0]),
        .in_first (s_tuser),
        .in_last  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .q_ctl    (q_ctl)
    );

    pcpa_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .q_ctl     (q_ctl),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
